// File: rtl/core/kfli_pkg.sv
// shared constants and codes for the keyframe linear interpolator
package kfli_pkg;

	// payload widths
	localparam int TIME_W  = 16;
	localparam int VALUE_W = 16;
	localparam int FRAC_W  = 16;
	localparam int KIND_W  = 2;
	localparam int KIDX_W  = 6;
	localparam int COMP_W  = 3;
	localparam int DIMS_W  = 4;
	localparam int KCNT_W  = 7;

	// parameter defaults
	localparam int MAX_KEYS_DEF = 64;
	localparam int MAX_DIM_DEF  = 8;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_TIME  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_VALUE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	// register indexes (paddr bit 2)
	localparam logic REG_COMPONENTS = 1'b0;
	localparam logic REG_KEY_COUNT  = 1'b1;

	// apb
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

endpackage

// File: rtl/core/keyframe_linear_interpolator.sv
// keyframe track with segment search, serial fraction divide and per-component lerp
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------------
//  request  | start / busy            | kind, key_index, component, key_time, key_value,
//           |                         | query_time
//  result   | result_valid (1 cycle)  | out_component, value, last, out_of_range
//  config   | apb psel/penable/pready | paddr, pwdata, prdata
//
// a load request is taken while idle; busy stays low
// an in-range query runs a segment search (one key time read per cycle from the time ram),
// the serial divider, then per component two value ram reads, a multiply, a round and add;
// a clamped query reads the end key values; reset clears the sequencer and result_valid
// and the config registers; the key rams hold garbage until written
// results cannot be stalled: each result is shown for exactly one cycle
module keyframe_linear_interpolator #(
	parameter int MAX_KEYS = kfli_pkg::MAX_KEYS_DEF,
	parameter int MAX_DIM  = kfli_pkg::MAX_DIM_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               start,
	output logic                               busy,
	input  logic [kfli_pkg::KIND_W-1:0]        kind,
	input  logic [kfli_pkg::KIDX_W-1:0]        key_index,
	input  logic [kfli_pkg::COMP_W-1:0]        component,
	input  logic [kfli_pkg::TIME_W-1:0]        key_time,
	input  logic signed [kfli_pkg::VALUE_W-1:0] key_value,
	input  logic [kfli_pkg::TIME_W-1:0]        query_time,
	// result channel
	output logic                               result_valid,
	output logic [kfli_pkg::COMP_W-1:0]        out_component,
	output logic signed [kfli_pkg::VALUE_W-1:0] value,
	output logic                               last,
	output logic                               out_of_range,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [kfli_pkg::APB_AW-1:0]        paddr,
	input  logic [kfli_pkg::APB_DW-1:0]        pwdata,
	output logic [kfli_pkg::APB_DW-1:0]        prdata,
	output logic                               pready
);
	import kfli_pkg::*;

	localparam int KAW = $clog2(MAX_KEYS);
	localparam int VAW = $clog2(MAX_KEYS * MAX_DIM);
	localparam logic [10:0]   KEYS_LIM = 11'(MAX_KEYS);
	localparam logic [4:0]    DIMS_LIM = 5'(MAX_DIM);
	localparam logic [VAW-1:0] DIM_OFS = VAW'(MAX_DIM);

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_TL   = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_WALK = 4'd3;
	localparam logic [3:0] S_DIV  = 4'd4;
	localparam logic [3:0] S_RV0  = 4'd5;
	localparam logic [3:0] S_RV1  = 4'd6;
	localparam logic [3:0] S_MUL  = 4'd7;
	localparam logic [3:0] S_ADD  = 4'd8;

	logic [3:0] state_q;

	// configuration registers
	logic [DIMS_W-1:0] components_q;
	logic [KCNT_W-1:0] key_count_q;

	// query registers
	logic [TIME_W-1:0]  q_q;
	logic [TIME_W-1:0]  t_lo_q;
	logic [KAW-1:0]     i_q;
	logic [KAW-1:0]     top_key_q;
	logic [DIMS_W-1:0]  dim_m1_q;
	logic [DIMS_W-1:0]  k_q;
	logic               oor_q;
	logic [VAW-1:0]     base_q;
	logic [VALUE_W-1:0] v0_q;
	logic signed [33:0] prod_q;

	// result registers
	logic               result_valid_q;
	logic [COMP_W-1:0]  out_component_q;
	logic [VALUE_W-1:0] value_q;
	logic               last_flag_q;
	logic               out_oor_q;

	logic accept;
	logic cfg_wr;
	logic key_ok;
	logic comp_ok;
	logic t_we;
	logic v_we;
	logic [KAW-1:0]     t_waddr;
	logic [VAW-1:0]     v_waddr;
	logic [KAW-1:0]     t_raddr;
	logic [VAW-1:0]     v_raddr;
	logic [TIME_W-1:0]  t_rdata;
	logic [VALUE_W-1:0] v_rdata;

	logic [10:0]        kc11;
	logic [KAW-1:0]     top_key_d;
	logic [4:0]         comp5;
	logic [DIMS_W-1:0]  dim_m1_d;

	logic               walk_on;
	logic               div_start;
	logic               div_done;
	logic [FRAC_W-1:0]  frac;
	logic [TIME_W-1:0]  div_num;
	logic [TIME_W-1:0]  div_den;

	logic signed [16:0] diff;
	logic signed [16:0] frac_s;
	logic signed [33:0] mul;
	logic signed [33:0] rnd;
	logic signed [18:0] sum;
	logic [VALUE_W-1:0] lerp;
	logic               comp_last;

	assign accept = start && !busy;
	assign busy   = state_q != S_IDLE;

	// apb register file
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			components_q <= DIMS_W'(1);
			key_count_q  <= KCNT_W'(2);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_COMPONENTS: components_q <= pwdata[DIMS_W-1:0];
				REG_KEY_COUNT:  key_count_q  <= pwdata[KCNT_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_COMPONENTS: prdata = APB_DW'(components_q);
			REG_KEY_COUNT:  prdata = APB_DW'(key_count_q);
			default:        prdata = '0;
		endcase
	end

	// load writes into the key rams
	always_comb begin
		key_ok  = 11'(key_index) < KEYS_LIM;
		comp_ok = 5'(component) < DIMS_LIM;
		t_we    = accept && (kind == KIND_TIME) && key_ok;
		v_we    = accept && (kind == KIND_VALUE) && key_ok && comp_ok;
		t_waddr = KAW'(key_index);
		v_waddr = VAW'(VAW'(key_index) * DIM_OFS + VAW'(component));
	end

	// effective key count and component count, clamped
	always_comb begin
		kc11  = 11'(key_count_q);
		comp5 = 5'(components_q);
		priority if (kc11 < 11'd2) begin
			top_key_d = KAW'(1);
		end else if (kc11 > KEYS_LIM) begin
			top_key_d = KAW'(MAX_KEYS - 1);
		end else begin
			top_key_d = KAW'(kc11 - 11'd1);
		end
		priority if (comp5 == 5'd0) begin
			dim_m1_d = '0;
		end else if (comp5 > DIMS_LIM) begin
			dim_m1_d = DIMS_W'(DIMS_LIM - 5'd1);
		end else begin
			dim_m1_d = DIMS_W'(comp5 - 5'd1);
		end
	end

	// time ram read address follows the search
	always_comb begin
		unique case (state_q)
			S_IDLE:  t_raddr = '0;
			S_TL:    t_raddr = top_key_q;
			S_CHK:   t_raddr = KAW'(1);
			S_WALK:  t_raddr = i_q + KAW'(2);
			default: t_raddr = '0;
		endcase
	end

	// value ram read address: lower key, then upper key
	always_comb begin
		if (state_q == S_RV1 && !oor_q) begin
			v_raddr = base_q + DIM_OFS + VAW'(k_q);
		end else begin
			v_raddr = base_q + VAW'(k_q);
		end
	end

	kfli_ram #(
		.WIDTH(TIME_W),
		.DEPTH(MAX_KEYS)
	) u_time_ram (
		.clk  (clk),
		.we   (t_we),
		.waddr(t_waddr),
		.wdata(key_time),
		.raddr(t_raddr),
		.rdata(t_rdata)
	);

	kfli_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(MAX_KEYS * MAX_DIM)
	) u_value_ram (
		.clk  (clk),
		.we   (v_we),
		.waddr(v_waddr),
		.wdata(key_value),
		.raddr(v_raddr),
		.rdata(v_rdata)
	);

	// segment search step and divider launch
	always_comb begin
		walk_on   = ((i_q + KAW'(1)) < top_key_q) && (q_q >= t_rdata);
		div_start = (state_q == S_WALK) && !walk_on;
		div_num   = q_q - t_lo_q;
		div_den   = t_rdata - t_lo_q;
	end

	kfli_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_num),
		.divisor (div_den),
		.done    (div_done),
		.quotient(frac)
	);

	// difference times fraction
	always_comb begin
		diff   = $signed({v_rdata[VALUE_W-1], v_rdata}) - $signed({v0_q[VALUE_W-1], v0_q});
		frac_s = $signed({1'b0, frac});
		mul    = diff * frac_s;
	end

	// round half up, add base value, saturate
	always_comb begin
		rnd = prod_q + 34'sd32768;
		sum = 19'($signed(rnd[33:16])) + 19'($signed(v0_q));
		priority if (sum > 19'sd32767) begin
			lerp = 16'h7fff;
		end else if (sum < -19'sd32768) begin
			lerp = 16'h8000;
		end else begin
			lerp = sum[VALUE_W-1:0];
		end
		comp_last = k_q == dim_m1_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && kind == KIND_QUERY) begin
						state_q <= S_TL;
					end
				end
				S_TL: state_q <= S_CHK;
				S_CHK: begin
					if (q_q < t_lo_q || q_q >= t_rdata) begin
						state_q <= S_RV0;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (!walk_on) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_RV0;
					end
				end
				S_RV0: state_q <= S_RV1;
				S_RV1: begin
					if (oor_q) begin
						result_valid_q <= 1'b1;
						state_q        <= comp_last ? S_IDLE : S_RV0;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					result_valid_q <= 1'b1;
					state_q        <= comp_last ? S_IDLE : S_RV0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// query datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				q_q       <= query_time;
				top_key_q <= top_key_d;
				dim_m1_q  <= dim_m1_d;
				k_q       <= '0;
				oor_q     <= 1'b0;
				i_q       <= '0;
			end
			S_TL: t_lo_q <= t_rdata;
			S_CHK: begin
				i_q <= '0;
				if (q_q < t_lo_q) begin
					oor_q  <= 1'b1;
					base_q <= '0;
				end else if (q_q >= t_rdata) begin
					oor_q  <= 1'b1;
					base_q <= VAW'(VAW'(top_key_q) * DIM_OFS);
				end
			end
			S_WALK: begin
				if (walk_on) begin
					t_lo_q <= t_rdata;
					i_q    <= i_q + KAW'(1);
				end else begin
					base_q <= VAW'(VAW'(i_q) * DIM_OFS);
				end
			end
			S_DIV: ;
			S_RV0: ;
			S_RV1: begin
				v0_q <= v_rdata;
				if (oor_q) begin
					out_component_q <= k_q[COMP_W-1:0];
					value_q         <= v_rdata;
					last_flag_q     <= comp_last;
					out_oor_q       <= 1'b1;
					k_q             <= k_q + DIMS_W'(1);
				end
			end
			S_MUL: prod_q <= mul;
			S_ADD: begin
				out_component_q <= k_q[COMP_W-1:0];
				value_q         <= lerp;
				last_flag_q     <= comp_last;
				out_oor_q       <= 1'b0;
				k_q             <= k_q + DIMS_W'(1);
			end
			default: ;
		endcase
	end

	assign result_valid  = result_valid_q;
	assign out_component = out_component_q;
	assign value         = $signed(value_q);
	assign last          = last_flag_q;
	assign out_of_range  = out_oor_q;

	// results never come back to back
	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back to back results");

	// the final component ends the query
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy)
		else $error("still busy after final component");

	// a non-final component keeps the block busy
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("idle before final component");

	// divider finishes only while the sequencer waits for it
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider done outside wait state");

	// search never runs past the second to last key
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> i_q < top_key_q)
		else $error("segment search out of bounds");

endmodule

// File: rtl/core/kfli_ram.sv
// generic single write, single read ram with registered read data
module kfli_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/kfli_div.sv
// serial restoring divider, one quotient bit per cycle, forms (dividend << 16) / divisor
module kfli_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [kfli_pkg::TIME_W-1:0] dividend,
	input  logic [kfli_pkg::TIME_W-1:0] divisor,
	output logic                       done,
	output logic [kfli_pkg::FRAC_W-1:0] quotient
);
	import kfli_pkg::*;

	localparam int CNT_W = $clog2(FRAC_W);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] dvs_q;
	logic [FRAC_W-1:0] quo_q;

	logic [TIME_W:0]   rem2;
	logic              ge;
	logic [TIME_W-1:0] rem_nxt;

	// one trial subtract per step
	always_comb begin
		rem2    = {rem_q, 1'b0};
		ge      = rem2 >= {1'b0, dvs_q};
		rem_nxt = ge ? TIME_W'(rem2 - {1'b0, dvs_q}) : rem2[TIME_W-1:0];
	end

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(FRAC_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[FRAC_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: bench/keyframe_linear_interpolator_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the keyframe linear interpolator
module keyframe_linear_interpolator_tb;
	import kfli_pkg::*;

	localparam int NKEYS = MAX_KEYS_DEF;
	localparam int NDIM  = MAX_DIM_DEF;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int IDLE_HEAVY    = 83;
	localparam int IDLE_LIGHT    = 11;
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_ITEMS  = 500;
	localparam int PRINT_CAP     = 50;

	typedef struct packed {
		logic [COMP_W-1:0]  comp;
		logic [VALUE_W-1:0] value;
		logic               last;
		logic               clamped;
	} sample_t;

	// track copy, lerp prediction and in-order compare of the interpolated samples
	class track_scoreboard;
		logic [TIME_W-1:0]         key_times[NKEYS];
		logic signed [VALUE_W-1:0] key_values[NKEYS*NDIM];
		bit                        value_written[NKEYS*NDIM];
		logic [DIMS_W-1:0]         components;
		logic [KCNT_W-1:0]         key_count;
		sample_t                   pending_samples[$];
		int mismatch_count, samples_checked, queries_seen, clamped_seen;

		function new();
			components      = 1;
			key_count       = 2;
			mismatch_count  = 0;
			samples_checked = 0;
			queries_seen    = 0;
			clamped_seen    = 0;
		endfunction

		function int unsigned active_dims();
			if (components == 0) return 1;
			if (components > NDIM) return NDIM;
			return components;
		endfunction

		function int unsigned active_keys();
			if (key_count < 2) return 2;
			if (key_count > NKEYS) return NKEYS;
			return key_count;
		endfunction

		function void set_register(logic sel, logic [APB_DW-1:0] data);
			if (sel == REG_COMPONENTS) components = data[DIMS_W-1:0];
			else key_count = data[KCNT_W-1:0];
		endfunction

		// apply a load, or queue the samples a query should produce
		function void note_request(logic [KIND_W-1:0] k, logic [KIDX_W-1:0] ki,
			logic [COMP_W-1:0] ci, logic [TIME_W-1:0] kt, logic [VALUE_W-1:0] kv,
			logic [TIME_W-1:0] qt);
			int unsigned dims, nkeys, seg, span, offset, frac, src;
			int v0, v1, v;
			longint delta;
			bit clamped, clamp_high;
			sample_t s;
			case (k)
				KIND_TIME: key_times[ki] = kt;
				KIND_VALUE: begin
					key_values[ki * NDIM + ci] = kv;
					value_written[ki * NDIM + ci] = 1'b1;
				end
				KIND_QUERY: begin
					queries_seen++;
					dims = active_dims();
					nkeys = active_keys();
					seg = 0;
					frac = 0;
					clamped = 0;
					clamp_high = 0;
					// clamp to the end keys, else walk up to the segment holding the query
					if (qt < key_times[0]) begin
						clamped = 1;
					end else if (qt >= key_times[nkeys - 1]) begin
						clamped = 1;
						clamp_high = 1;
					end else begin
						while (seg < nkeys - 2 && qt >= key_times[seg + 1]) seg++;
						span = int'(key_times[seg + 1]) - int'(key_times[seg]);
						offset = int'(qt) - int'(key_times[seg]);
						if (span != 0) frac = (offset << 16) / span;
						if (frac > 'hFFFF) frac = 'hFFFF;
					end
					src = clamp_high ? nkeys - 1 : 0;
					for (int c = 0; c < dims; c++) begin
						if (clamped) begin
							v = key_values[src * NDIM + c];
						end else begin
							// q0.16 fraction times the step, halves rounded up
							v0 = key_values[seg * NDIM + c];
							v1 = key_values[(seg + 1) * NDIM + c];
							delta = (longint'(v1 - v0) * longint'(frac) + 32768) >>> 16;
							v = v0 + int'(delta);
							if (v > 32767) v = 32767;
							if (v < -32768) v = -32768;
						end
						s.comp = COMP_W'(c);
						s.value = VALUE_W'(v);
						s.last = (c == dims - 1);
						s.clamped = clamped;
						pending_samples.push_back(s);
					end
					if (clamped) clamped_seen++;
				end
				default: ;
			endcase
		endfunction

		task flag_mismatch(string what);
			if (mismatch_count < PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
			mismatch_count++;
		endtask

		task check_sample(logic [COMP_W-1:0] comp, logic [VALUE_W-1:0] val, logic lst,
			logic clamped);
			sample_t want;
			if (pending_samples.size() == 0) begin
				flag_mismatch($sformatf("unexpected result, component %0d value %0d",
					comp, $signed(val)));
				return;
			end
			want = pending_samples.pop_front();
			samples_checked++;
			if (comp !== want.comp)
				flag_mismatch($sformatf("out_component %0d, want %0d", comp, want.comp));
			if (val !== want.value)
				flag_mismatch($sformatf("component %0d value %0d, want %0d", want.comp,
					$signed(val), $signed(want.value)));
			if (lst !== want.last)
				flag_mismatch($sformatf("component %0d last %b, want %b", want.comp, lst,
					want.last));
			if (clamped !== want.clamped)
				flag_mismatch($sformatf("component %0d out_of_range %b, want %b", want.comp,
					clamped, want.clamped));
		endtask

		task check_drained();
			if (pending_samples.size() != 0)
				flag_mismatch($sformatf("%0d expected results never arrived",
					pending_samples.size()));
		endtask
	endclass

	logic clk, arst_n;
	logic start, busy;
	logic [KIND_W-1:0]  kind;
	logic [KIDX_W-1:0]  key_index;
	logic [COMP_W-1:0]  component;
	logic [TIME_W-1:0]  key_time;
	logic signed [VALUE_W-1:0] key_value;
	logic [TIME_W-1:0]  query_time;
	logic result_valid;
	logic [COMP_W-1:0]  out_component;
	logic signed [VALUE_W-1:0] value;
	logic last, out_of_range;
	logic psel, penable, pwrite, pready;
	logic [APB_AW-1:0]  paddr;
	logic [APB_DW-1:0]  pwdata, prdata;

	track_scoreboard sb;
	int idle_pct;
	int request_total;
	int register_writes;

	keyframe_linear_interpolator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.key_index(key_index),
		.component(component),
		.key_time(key_time),
		.key_value(key_value),
		.query_time(query_time),
		.result_valid(result_valid),
		.out_component(out_component),
		.value(value),
		.last(last),
		.out_of_range(out_of_range),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop
	initial begin
		#8ms;
		$display("== FAIL ==");
		$finish;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check_sample(out_component, value, last, out_of_range);
	end

	// one request: optional idle gap, then hold start until accepted
	task automatic send_request(input logic [KIND_W-1:0] k, input logic [KIDX_W-1:0] ki,
		input logic [COMP_W-1:0] ci, input logic [TIME_W-1:0] kt,
		input logic [VALUE_W-1:0] kv, input logic [TIME_W-1:0] qt);
		int gap;
		gap = 0;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct && gap < 40) gap++;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		key_index <= ki;
		component <= ci;
		key_time <= kt;
		key_value <= kv;
		query_time <= qt;
		do @(posedge clk); while (busy);
		sb.note_request(k, ki, ci, kt, kv, qt);
		request_total++;
	endtask

	// apb write: setup then access, then back to idle
	task automatic write_register(input logic sel, input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(sel, data);
		register_writes++;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// drop start and let the block finish before touching registers
	task automatic wait_idle();
		start <= 1'b0;
		while (sb.pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] random_value();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return VALUE_W'($urandom);
		endcase
	endfunction

	// load every value the current track can read that was never written
	task automatic fill_values();
		int unsigned nkeys, dims;
		nkeys = sb.active_keys();
		dims = sb.active_dims();
		for (int i = 0; i < nkeys; i++)
			for (int c = 0; c < dims; c++)
				if (!sb.value_written[i * NDIM + c])
					send_request(KIND_VALUE, KIDX_W'(i), COMP_W'(c), '0, random_value(), '0);
	endtask

	// rewrite the used key times, ascending unless broken, plus a few values
	task automatic build_track(input bit broken);
		int unsigned nkeys, t, stride;
		nkeys = sb.active_keys();
		t = $urandom_range(0, 3000);
		stride = 60000 / nkeys;
		for (int i = 0; i < nkeys; i++) begin
			if (broken) begin
				send_request(KIND_TIME, KIDX_W'(i), '0, TIME_W'($urandom), '0, '0);
			end else begin
				send_request(KIND_TIME, KIDX_W'(i), '0, TIME_W'(t), '0, '0);
				t += ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, stride);
			end
		end
		repeat (8)
			send_request(KIND_VALUE, KIDX_W'($urandom_range(nkeys - 1)),
				COMP_W'($urandom_range(sb.active_dims() - 1)), '0, random_value(), '0);
		fill_values();
	endtask

	// mostly queries aimed at segments and end keys, some loads and unused kinds
	task automatic random_request();
		int unsigned nkeys, seg, pick;
		logic [TIME_W-1:0] q;
		nkeys = sb.active_keys();
		seg = $urandom_range(nkeys - 2);
		pick = $urandom_range(99);
		q = TIME_W'($urandom);
		if (pick < 8) begin
			send_request(KIND_TIME, KIDX_W'($urandom), COMP_W'($urandom), TIME_W'($urandom),
				VALUE_W'($urandom), TIME_W'($urandom));
		end else if (pick < 16) begin
			send_request(KIND_VALUE, KIDX_W'($urandom), COMP_W'($urandom), TIME_W'($urandom),
				random_value(), TIME_W'($urandom));
		end else if (pick < 19) begin
			send_request(KIND_UNUSED, KIDX_W'($urandom), COMP_W'($urandom), TIME_W'($urandom),
				VALUE_W'($urandom), TIME_W'($urandom));
		end else begin
			if (pick < 60) q = TIME_W'($urandom_range(sb.key_times[seg], sb.key_times[seg + 1]));
			else if (pick < 72) q = sb.key_times[$urandom_range(nkeys - 1)];
			else if (pick < 78) q = sb.key_times[0] - TIME_W'($urandom_range(1, 4));
			else if (pick < 84) q = sb.key_times[nkeys - 1] + TIME_W'($urandom_range(0, 3));
			send_request(KIND_QUERY, KIDX_W'($urandom), COMP_W'($urandom), TIME_W'($urandom),
				VALUE_W'($urandom), q);
		end
	endtask

	// stimulus
	initial begin
		int unsigned dims_cfg, keys_cfg;
		int random_base, drain;
		sb = new();
		idle_pct = 0;
		request_total = 0;
		register_writes = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		kind <= '0;
		key_index <= '0;
		component <= '0;
		key_time <= '0;
		key_value <= '0;
		query_time <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, one component over two keys
		idle_pct = IDLE_LIGHT;
		send_request(KIND_TIME, 6'd0, '0, 16'd16, '0, '0);
		send_request(KIND_TIME, 6'd1, '0, 16'hFFFF, '0, '0);
		send_request(KIND_VALUE, 6'd0, 3'd0, '0, 16'h8000, '0);
		send_request(KIND_VALUE, 6'd1, 3'd0, '0, 16'h7FFF, '0);
		send_request(KIND_QUERY, '0, '0, '0, '0, 16'd0);
		send_request(KIND_QUERY, '0, '0, '0, '0, 16'd16);
		send_request(KIND_QUERY, '0, '0, '0, '0, 16'd40000);
		send_request(KIND_QUERY, '0, '0, '0, '0, 16'hFFFF);

		// directed: all eight components over four keys
		wait_idle();
		write_register(REG_COMPONENTS, 32'd8);
		write_register(REG_KEY_COUNT, 32'd4);
		send_request(KIND_TIME, 6'd1, '0, 16'd300, '0, '0);
		send_request(KIND_TIME, 6'd2, '0, 16'd40000, '0, '0);
		send_request(KIND_TIME, 6'd3, '0, 16'hFFFF, '0, '0);
		fill_values();
		send_request(KIND_VALUE, 6'd2, 3'd7, '0, 16'hFFFF, '0);
		send_request(KIND_VALUE, 6'd3, 3'd7, '0, 16'h7FFF, '0);
		send_request(KIND_QUERY, '0, '0, '0, '0, 16'd15);
		send_request(KIND_QUERY, '0, '0, '0, '0, 16'd299);
		send_request(KIND_QUERY, '0, '0, '0, '0, 16'd300);
		send_request(KIND_QUERY, '0, '0, '0, '0, 16'd65534);
		send_request(KIND_QUERY, '0, '0, '0, '0, 16'hFFFF);
		send_request(KIND_UNUSED, '1, '1, '1, '1, '1);
		// key times out of order
		send_request(KIND_TIME, 6'd2, '0, 16'd200, '0, '0);
		send_request(KIND_QUERY, '0, '0, '0, '0, 16'd250);
		send_request(KIND_QUERY, '0, '0, '0, '0, 16'd350);
		send_request(KIND_TIME, 6'd0, '0, 16'd0, '0, '0);
		send_request(KIND_QUERY, '0, '0, '0, '0, 16'd0);

		// random phases over register settings and idle patterns
		random_base = request_total;
		for (int p = 0; p < 8 || request_total - random_base < RANDOM_ITEMS; p++) begin
			wait_idle();
			case (p % 8)
				0: begin dims_cfg = 1; keys_cfg = 2; end
				1: begin dims_cfg = 8; keys_cfg = 12; end
				2: begin dims_cfg = 0; keys_cfg = 0; end
				3: begin dims_cfg = 15; keys_cfg = 6; end
				4: begin dims_cfg = 4; keys_cfg = 1; end
				5: begin dims_cfg = $urandom_range(15); keys_cfg = $urandom_range(15); end
				6: begin dims_cfg = 1; keys_cfg = 127; end
				default: begin
					dims_cfg = $urandom_range(1, 8);
					keys_cfg = $urandom_range(2, 8);
				end
			endcase
			case (p % 3)
				0: idle_pct = 0;
				1: idle_pct = IDLE_HEAVY;
				default: idle_pct = IDLE_LIGHT;
			endcase
			write_register(REG_COMPONENTS, dims_cfg);
			write_register(REG_KEY_COUNT, keys_cfg);
			build_track(p % 5 == 4);
			repeat (25) random_request();
		end

		// drain
		start <= 1'b0;
		drain = 0;
		while (sb.pending_samples.size() != 0 && drain < 2000) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.check_drained();
		$display("run covered %0d requests, %0d queries, %0d register writes",
			request_total, sb.queries_seen, register_writes);
		$display("%0d samples checked, %0d queries clamped to an end key, %0d mismatches",
			sb.samples_checked, sb.clamped_seen, sb.mismatch_count);
		if (sb.mismatch_count == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
